// ----- rtl/matmul_accumulate_activation_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the matrix multiply block
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MATMUL_ACCUMULATE_ACTIVATION_MACROS_SVH
`define MATMUL_ACCUMULATE_ACTIVATION_MACROS_SVH

// Same-cycle implication check.
`define MAC_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define MAC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mac_pkg.sv -----
// ---------------------------------------------------------------------------
// mac_pkg
// Shared codes, constants and the sigmoid lookup table.
// ---------------------------------------------------------------------------
package mac_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int ACC_W      = 64;
  localparam int FRAC_BITS  = 8;
  localparam int LUT_DEPTH  = 256;
  localparam int LUT_W      = 9;

  typedef enum logic [1:0] {
    KIND_A   = 2'd0,
    KIND_B   = 2'd1,
    KIND_C   = 2'd2,
    KIND_RUN = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_M   = 2'd0,
    REG_COLS_N   = 2'd1,
    REG_INNER_K  = 2'd2,
    REG_ACT_MODE = 2'd3
  } reg_idx_t;

  localparam logic signed [ACC_W-1:0] ACC_LIMIT  = 64'sd1 <<< 61;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd128;
  localparam logic [63:0]             EXPM_SIXTEENTH = 64'd4034748384;

  typedef logic [LUT_W-1:0] sig_lut_t [LUT_DEPTH];

  // Entry e stands for z = (e - 128) / 16; value is 256 * sigmoid(z).
  function automatic sig_lut_t sig_lut_build();
    sig_lut_t    lut;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    int          steps;
    for (int e = 0; e < LUT_DEPTH; e++) begin
      steps = (e >= 128) ? (e - 128) : (128 - e);
      p = 64'd1 << 32;
      for (int n = 0; n < steps; n++) begin
        p = (p * EXPM_SIXTEENTH) >> 32;
      end
      d   = (64'd1 << 32) + p;
      num = (64'd1 << 40) + (d >> 1);
      rem = '0;
      q   = '0;
      // shift-subtract division, one quotient bit a step
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= d) begin
          rem  = rem - d;
          q[b] = 1'b1;
        end
      end
      if (e < 128) begin
        q = 64'd256 - q;
      end
      lut[e] = LUT_W'(q);
    end
    return lut;
  endfunction

  localparam sig_lut_t SIG_LUT = sig_lut_build();

endpackage

// ----- rtl/mac_in_if.sv -----
// ---------------------------------------------------------------------------
// mac_in_if
// Command channel: element loads and the compute command.
// ---------------------------------------------------------------------------
interface mac_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [2:0]                   row_index;
  logic [2:0]                   col_index;
  logic signed [DATA_WIDTH-1:0] elem_value;

  modport source (output valid, kind, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, kind, row_index, col_index, elem_value, output ready);
endinterface

// ----- rtl/mac_out_if.sv -----
// ---------------------------------------------------------------------------
// mac_out_if
// Result channel: one activated element per transaction.
// ---------------------------------------------------------------------------
interface mac_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   out_row;
  logic [2:0]                   out_col;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic                         out_last;

  modport source (output valid, out_row, out_col, out_value, out_last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

// ----- rtl/mac_cfg_if.sv -----
// ---------------------------------------------------------------------------
// mac_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface mac_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mac_pkg::CFG_IDX_W-1:0]  index;
  logic [mac_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mac_ram.sv -----
// ---------------------------------------------------------------------------
// mac_ram
// Simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module mac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/matmul_accumulate_activation.sv -----
// ---------------------------------------------------------------------------
// matmul_accumulate_activation
// Loads: a load command completes while idle; cmd.ready stays high in idle.
// Compute: result elements are produced one after another in row-major order
//   by the single multiply-accumulate unit, reading through the one read port
//   of each element store.
// Each element passes through the ISSUE, DRAIN, FINISH and ACT states in turn.
// Reset (rst, synchronous): idle, no result pending, registers at 8/8/8/ReLU;
//   store contents are undefined until written.
// ---------------------------------------------------------------------------
`include "matmul_accumulate_activation_macros.svh"

module matmul_accumulate_activation #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16
) (
  input logic      clk,
  input logic      rst,
  mac_in_if.sink   cmd,
  mac_out_if.source res,
  mac_cfg_if.sink  cfg
);
  import mac_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * DATA_WIDTH;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // One-hot sequencer for the compute pass.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ISSUE  = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_FINISH = 5'b01000,
    S_ACT    = 5'b10000
  } state_t;

  // Map a dimension register to its last index: 0 acts as 1, cap at MAX_DIM.
  function automatic logic [IW-1:0] dim_last(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (v > CFG_DATA_W'(MAX_DIM)) begin
      return IW'(MAX_DIM - 1);
    end else begin
      return IW'(v - 1'b1);
    end
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  // Clamp to the accumulator limit of +-2^61.
  function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [ACC_W-1:0] v);
    if (v > ACC_LIMIT) begin
      return ACC_LIMIT;
    end else if (v < -ACC_LIMIT) begin
      return -ACC_LIMIT;
    end else begin
      return v;
    end
  endfunction

  // ---- configuration registers -------------------------------------------
  logic [CFG_DATA_W-1:0] rows_m;
  logic [CFG_DATA_W-1:0] cols_n;
  logic [CFG_DATA_W-1:0] inner_k;
  logic                  act_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m   <= CFG_DATA_W'(8);
      cols_n   <= CFG_DATA_W'(8);
      inner_k  <= CFG_DATA_W'(8);
      act_mode <= 1'b0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_ROWS_M:   rows_m   <= cfg.data;
        REG_COLS_N:   cols_n   <= cfg.data;
        REG_INNER_K:  inner_k  <= cfg.data;
        REG_ACT_MODE: act_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  logic [IW-1:0] m_last;
  logic [IW-1:0] n_last;
  logic [IW-1:0] k_last;

  assign m_last = dim_last(rows_m);
  assign n_last = dim_last(cols_n);
  assign k_last = dim_last(inner_k);

  // ---- sequencer state ----------------------------------------------------
  state_t        state;
  logic [IW-1:0] i_cnt;
  logic [IW-1:0] j_cnt;
  logic [IW-1:0] k_cnt;
  logic          last_elem;
  logic          out_load;

  assign last_elem = (i_cnt == m_last) && (j_cnt == n_last);

  // In S_ACT, load the result register when it is empty or being drained this cycle.
  assign out_load  = (state == S_ACT) && (!res.valid || res.ready);

  assign cmd.ready = (state == S_IDLE);

  // ---- element stores -----------------------------------------------------
  logic                  wr_in_range;
  logic [AW-1:0]         wr_addr;
  logic                  cmd_take;
  logic                  we_a;
  logic                  we_b;
  logic                  we_c;
  logic [AW-1:0]         waddr_c;
  logic [DATA_WIDTH-1:0] wdata_c;
  logic [DATA_WIDTH-1:0] a_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic [DATA_WIDTH-1:0] c_q;
  logic signed [DATA_WIDTH-1:0] act_val;

  assign cmd_take    = cmd.valid && cmd.ready;
  // Drop writes whose row or column is outside the store.
  assign wr_in_range = ({1'b0, cmd.row_index} < 4'(MAX_DIM)) &&
                       ({1'b0, cmd.col_index} < 4'(MAX_DIM));
  assign wr_addr     = addr_of(cmd.row_index[IW-1:0], cmd.col_index[IW-1:0]);

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    we_c = 1'b0;
    if (cmd_take && wr_in_range) begin
      unique case (kind_t'(cmd.kind))
        KIND_A:   we_a = 1'b1;
        KIND_B:   we_b = 1'b1;
        KIND_C:   we_c = 1'b1;
        KIND_RUN: ;
        default: ;
      endcase
    end
  end

  // C shares its write port between loads and the write-back of results.
  assign waddr_c = out_load ? addr_of(i_cnt, j_cnt) : wr_addr;
  assign wdata_c = out_load ? act_val : cmd.elem_value;

  mac_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (cmd.elem_value),
    .raddr (addr_of(i_cnt, k_cnt)),
    .rdata (a_q)
  );

  mac_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (cmd.elem_value),
    .raddr (addr_of(k_cnt, j_cnt)),
    .rdata (b_q)
  );

  mac_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_c_store (
    .clk   (clk),
    .we    (we_c || out_load),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (addr_of(i_cnt, j_cnt)),
    .rdata (c_q)
  );

  // ---- multiply-accumulate pipeline ---------------------------------------
  // Stage 1: store read data valid. Stage 2: product registered.
  logic                    rd_vld;
  logic                    rd_first;
  logic                    rd_last;
  logic                    mul_vld;
  logic                    mul_last;
  logic signed [PW-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] c_scaled;

  assign c_scaled = ACC_W'(signed'(c_q)) <<< FRAC_BITS;

  always_comb begin
    acc_next = acc;
    if (rd_vld && rd_first) begin
      // seed with the initial C element, moved to 16 fraction bits
      acc_next = clamp_acc(c_scaled);
    end else if (mul_vld) begin
      acc_next = clamp_acc(acc + clamp_acc(ACC_W'(prod_q)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      rd_vld  <= (state == S_ISSUE);
      mul_vld <= rd_vld;
    end
    rd_first <= (k_cnt == '0);
    rd_last  <= (k_cnt == k_last);
    mul_last <= rd_last;
    if (rd_vld) begin
      prod_q <= PW'(signed'(a_q)) * PW'(signed'(b_q));
    end
    acc <= acc_next;
  end

  // ---- round, saturate, activate ------------------------------------------
  logic signed [ACC_W-1:0]      rnd;
  logic signed [DATA_WIDTH-1:0] sat_d;
  logic signed [DATA_WIDTH-1:0] sum_q;
  logic signed [33:0]           sig_x;
  logic [7:0]                   sig_e;
  logic [LUT_W-1:0]             sig_ent;

  // floor((acc + 128) / 256): nearest, ties toward +infinity
  assign rnd = (acc + ROUND_HALF) >>> FRAC_BITS;

  always_comb begin
    if (rnd > ACC_W'(DATA_MAX)) begin
      sat_d = DATA_MAX;
    end else if (rnd < ACC_W'(DATA_MIN)) begin
      sat_d = DATA_MIN;
    end else begin
      sat_d = DATA_WIDTH'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      sum_q <= sat_d;
    end
  end

  // Table index: 0 below -8, else (x + 2048) / 16 capped at 255.
  assign sig_x = 34'(sum_q) + 34'sd2048;

  always_comb begin
    if (sig_x < 0) begin
      sig_e = '0;
    end else if (sig_x[33:4] > 30'd255) begin
      sig_e = 8'd255;
    end else begin
      sig_e = sig_x[11:4];
    end
  end

  assign sig_ent = SIG_LUT[sig_e];

  always_comb begin
    if (act_mode) begin
      if (32'(sig_ent) > 32'(DATA_MAX)) begin
        act_val = DATA_MAX;
      end else begin
        act_val = DATA_WIDTH'(sig_ent);
      end
    end else begin
      act_val = (sum_q < 0) ? '0 : sum_q;
    end
  end

  // ---- sequencer ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // Loads complete here; only compute leaves idle.
          if (cmd_take && (kind_t'(cmd.kind) == KIND_RUN)) begin
            i_cnt <= '0;
            j_cnt <= '0;
            k_cnt <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          // Issue one A/B read pair per cycle along the inner dimension.
          if (k_cnt == k_last) begin
            k_cnt <= '0;
            state <= S_DRAIN;
          end else begin
            k_cnt <= k_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          // Wait for the final product to reach the accumulator.
          if (mul_vld && mul_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_ACT;
        end
        S_ACT: begin
          // Hold until the result register frees up, then advance row-major.
          if (out_load) begin
            if (last_elem) begin
              state <= S_IDLE;
            end else begin
              if (j_cnt == n_last) begin
                j_cnt <= '0;
                i_cnt <= i_cnt + 1'b1;
              end else begin
                j_cnt <= j_cnt + 1'b1;
              end
              state <= S_ISSUE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- result register ----------------------------------------------------
  logic                         out_valid;
  logic [2:0]                   out_row;
  logic [2:0]                   out_col;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic                         out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_row   <= 3'(i_cnt);
      out_col   <= 3'(j_cnt);
      out_value <= act_val;
      out_last  <= last_elem;
    end
  end

  assign res.valid     = out_valid;
  assign res.out_row   = out_row;
  assign res.out_col   = out_col;
  assign res.out_value = out_value;
  assign res.out_last  = out_last;

  // ---- assertions ---------------------------------------------------------
  `MAC_CHECK(a_idle_drained, state == S_IDLE, !mul_vld, "product in flight while idle")
  `MAC_CHECK(a_k_bound, state == S_ISSUE, k_cnt <= k_last, "inner index past inner_k")
  `MAC_CHECK(a_last_pos, res.valid && res.out_last, (res.out_row == 3'(m_last)) && (res.out_col == 3'(n_last)), "last flag on wrong element")
  `MAC_CHECK_NEXT(a_done_idle, out_load && last_elem, state == S_IDLE, "compute did not finish after last element")

endmodule

// ----- bench/mac_result_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GEMM result checker
// Watches the command, configuration and result channels of the matrix
// block. Keeps its own element stores and registers, predicts every emitted
// element when a compute transaction is accepted, and compares the result
// stream in order against the oldest prediction.
// ---------------------------------------------------------------------------
module mac_result_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_ready,
  input  logic [1:0]        cmd_kind,
  input  logic [2:0]        cmd_row,
  input  logic [2:0]        cmd_col,
  input  logic signed [15:0] cmd_value,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              res_valid,
  input  logic              res_ready,
  input  logic [2:0]        res_row,
  input  logic [2:0]        res_col,
  input  logic signed [15:0] res_value,
  input  logic              res_last,
  output int                fail_count,
  output int                pending
);
  import mac_pkg::*;

  localparam int MAX_DIM      = 8;
  localparam int REPORT_LINES = 40;

  typedef struct packed {
    logic [2:0]        row;
    logic [2:0]        col;
    logic signed [15:0] value;
    logic              last;
  } gemm_elem_t;

  logic signed [15:0] a_mat [MAX_DIM][MAX_DIM];
  logic signed [15:0] b_mat [MAX_DIM][MAX_DIM];
  logic signed [15:0] c_mat [MAX_DIM][MAX_DIM];
  logic signed [15:0] sig_table [256];
  logic [3:0]         rows_cfg;
  logic [3:0]         cols_cfg;
  logic [3:0]         inner_cfg;
  logic               act_sel;
  gemm_elem_t         expected_elems [$];

  // Sigmoid table: exp(-t) by repeated multiply with exp(-1/16), then
  // 256 / (1 + exp(-t)) rounded, mirrored for negative arguments.
  initial begin : build_sigmoid
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] s;
    int          steps;
    for (int e = 0; e < 256; e++) begin
      steps = (e >= 128) ? (e - 128) : (128 - e);
      p = 64'd1 << 32;
      repeat (steps) p = (p * EXPM_SIXTEENTH) >> 32;
      d = (64'd1 << 32) + p;
      s = ((64'd1 << 40) + (d >> 1)) / d;
      if (e < 128) s = 64'd256 - s;
      sig_table[e] = s[15:0];
    end
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LINES) $display("mismatch: %s", msg);
  endtask

  function automatic int dim_of(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic signed [15:0] activate(input logic signed [15:0] x);
    int e;
    if (!act_sel) return (x < 0) ? 16'sd0 : x;
    if (x < -16'sd2048) begin
      e = 0;
    end else begin
      e = (int'(x) + 2048) / 16;
      if (e > 255) e = 255;
    end
    return sig_table[e];
  endfunction

  // Full product for the current dimensions; each element is written back
  // into C. Products of two 16-bit values never reach the accumulator limit.
  function automatic void predict_product();
    int                 m;
    int                 n;
    int                 kk;
    longint             acc;
    longint             rounded;
    logic signed [15:0] sat;
    gemm_elem_t         elem;
    m  = dim_of(rows_cfg);
    n  = dim_of(cols_cfg);
    kk = dim_of(inner_cfg);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = longint'(c_mat[i][j]) * 256;
        for (int k = 0; k < kk; k++) begin
          acc += longint'(a_mat[i][k]) * longint'(b_mat[k][j]);
        end
        rounded = (acc + 128) >>> 8;
        if (rounded > 32767) sat = 16'sh7fff;
        else if (rounded < -32768) sat = -16'sh8000;
        else sat = 16'(rounded);
        elem.row   = 3'(i);
        elem.col   = 3'(j);
        elem.value = activate(sat);
        elem.last  = (i == m - 1) && (j == n - 1);
        c_mat[i][j] = elem.value;
        expected_elems.push_back(elem);
      end
    end
  endfunction

  always @(posedge clk) begin
    gemm_elem_t want;
    if (rst) begin
      rows_cfg   = 4'd8;
      cols_cfg   = 4'd8;
      inner_cfg  = 4'd8;
      act_sel    = 1'b0;
      fail_count = 0;
      expected_elems.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (expected_elems.size() == 0) begin
          report_mismatch($sformatf("result (%0d,%0d)=%0d with nothing expected",
                                    res_row, res_col, res_value));
        end else begin
          want = expected_elems.pop_front();
          if (res_row !== want.row)
            report_mismatch($sformatf("out_row %0d, expected %0d", res_row, want.row));
          if (res_col !== want.col)
            report_mismatch($sformatf("out_col %0d, expected %0d", res_col, want.col));
          if (res_value !== want.value)
            report_mismatch($sformatf("out_value %0d at (%0d,%0d), expected %0d",
                                      res_value, want.row, want.col, want.value));
          if (res_last !== want.last)
            report_mismatch($sformatf("out_last %0d at (%0d,%0d), expected %0d",
                                      res_last, want.row, want.col, want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_ROWS_M:   rows_cfg  = cfg_data;
          REG_COLS_N:   cols_cfg  = cfg_data;
          REG_INNER_K:  inner_cfg = cfg_data;
          REG_ACT_MODE: act_sel   = cfg_data[0];
          default: ;
        endcase
      end
      // 3-bit indexes cannot leave the 8x8 stores, so no write is dropped
      if (cmd_valid && cmd_ready) begin
        case (kind_t'(cmd_kind))
          KIND_A:   a_mat[cmd_row][cmd_col] = cmd_value;
          KIND_B:   b_mat[cmd_row][cmd_col] = cmd_value;
          KIND_C:   c_mat[cmd_row][cmd_col] = cmd_value;
          KIND_RUN: predict_product();
          default: ;
        endcase
      end
    end
    pending <= expected_elems.size();
  end

endmodule

// ----- bench/tb_matmul_accumulate_activation.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the matrix multiply-accumulate block with activation
// Loads A, B and C elements, issues compute commands under many register
// settings and random channel gaps, and lets the checker compare every
// emitted element with its own prediction.
// ---------------------------------------------------------------------------
module tb_matmul_accumulate_activation;
  import mac_pkg::*;

  localparam int MAX_DIM      = 8;
  localparam int DATA_W       = 16;
  localparam int RANDOM_ITEMS = 430;
  localparam int MAX_GAP      = 8;
  // settle time after draining, before touching registers
  localparam int LOAD_SETTLE  = 4;
  localparam int END_SETTLE   = 40;
  localparam int LONG_HOLD    = 300;
  // watchdog limit on the length of the whole run
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   items_sent  = 0;
  bit   cmd_steady  = 1'b0;
  bit   res_steady  = 1'b0;
  bit   long_hold_req = 1'b0;
  int   rows_eff;
  int   cols_eff;
  int   inner_eff;
  // which store entries hold a value; a compute never reads an empty one
  bit   a_set [MAX_DIM][MAX_DIM];
  bit   b_set [MAX_DIM][MAX_DIM];
  bit   c_set [MAX_DIM][MAX_DIM];

  mac_in_if  #(.DATA_WIDTH(DATA_W)) cmd_if ();
  mac_out_if #(.DATA_WIDTH(DATA_W)) res_if ();
  mac_cfg_if                        cfg_if ();

  matmul_accumulate_activation #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  mac_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_if.valid),
    .cmd_ready  (cmd_if.ready),
    .cmd_kind   (cmd_if.kind),
    .cmd_row    (cmd_if.row_index),
    .cmd_col    (cmd_if.col_index),
    .cmd_value  (cmd_if.elem_value),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_index  (cfg_if.index),
    .cfg_data   (cfg_if.data),
    .res_valid  (res_if.valid),
    .res_ready  (res_if.ready),
    .res_row    (res_if.out_row),
    .res_col    (res_if.out_col),
    .res_value  (res_if.out_value),
    .res_last   (res_if.out_last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int clamp_dim(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return MAX_DIM;
    return int'(v);
  endfunction

  // Mix of extremes, values near one in Q8.8 (so sums land in the sigmoid
  // range) and full-range noise.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return -16'sh8000;
      2:       return 16'sd0;
      3, 4, 5: return 16'($urandom_range(0, 1200)) - 16'sd600;
      6, 7:    return 16'($urandom_range(0, 160)) - 16'sd80;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly small dimensions; zero and values above eight exercise clamping.
  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1, 2:    return 4'd8;
      3:       return 4'($urandom_range(9, 15));
      4:       return 4'd1;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // Offer one command and hold it until the transaction completes. Valid is
  // left high so a back-to-back command needs no second assignment.
  task automatic send_cmd(input kind_t kind, input logic [2:0] row,
                          input logic [2:0] col, input logic signed [15:0] value);
    int gap;
    gap = cmd_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.kind       <= kind;
    cmd_if.row_index  <= row;
    cmd_if.col_index  <= col;
    cmd_if.elem_value <= value;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    items_sent++;
    case (kind)
      KIND_A:  a_set[row][col] = 1'b1;
      KIND_B:  b_set[row][col] = 1'b1;
      KIND_C:  c_set[row][col] = 1'b1;
      default: ;
    endcase
  endtask

  // Drop valid and hold off until every predicted result has arrived, then
  // let the last load finish inside the block.
  task automatic pause_until_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [3:0] data);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      cfg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
  endtask

  // Registers change only with the block idle.
  task automatic configure(input logic [3:0] rows, input logic [3:0] cols,
                           input logic [3:0] inner, input logic [3:0] act);
    pause_until_drained();
    write_reg(REG_ROWS_M, rows);
    write_reg(REG_COLS_N, cols);
    write_reg(REG_INNER_K, inner);
    write_reg(REG_ACT_MODE, act);
    cfg_if.valid <= 1'b0;
    rows_eff  = clamp_dim(rows);
    cols_eff  = clamp_dim(cols);
    inner_eff = clamp_dim(inner);
  endtask

  // Load whatever the current dimensions read and is still empty, then
  // issue the compute with random content in its ignored fields.
  task automatic run_product();
    for (int i = 0; i < rows_eff; i++)
      for (int k = 0; k < inner_eff; k++)
        if (!a_set[i][k]) send_cmd(KIND_A, 3'(i), 3'(k), pick_value());
    for (int k = 0; k < inner_eff; k++)
      for (int j = 0; j < cols_eff; j++)
        if (!b_set[k][j]) send_cmd(KIND_B, 3'(k), 3'(j), pick_value());
    for (int i = 0; i < rows_eff; i++)
      for (int j = 0; j < cols_eff; j++)
        if (!c_set[i][j]) send_cmd(KIND_C, 3'(i), 3'(j), pick_value());
    send_cmd(KIND_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
  endtask

  // Result side: draw a gap for every transaction; once on request, hold
  // ready low for a long stretch so the block backs up into its input.
  initial begin : result_sink
    int gap;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = res_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
    end
  end

  initial begin : stimulus
    int ops;
    int phase;
    int random_start;
    cmd_if.valid      <= 1'b0;
    cmd_if.kind       <= KIND_A;
    cmd_if.row_index  <= 3'd0;
    cmd_if.col_index  <= 3'd0;
    cmd_if.elem_value <= 16'sd0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_ROWS_M;
    cfg_if.data       <= 4'd0;
    rst               <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: 1x1x1 so a single product is easy to steer.
    configure(4'd1, 4'd1, 4'd1, 4'd0);
    // positive saturation
    send_cmd(KIND_A, 3'd0, 3'd0, 16'sh7fff);
    send_cmd(KIND_B, 3'd0, 3'd0, 16'sh7fff);
    send_cmd(KIND_C, 3'd0, 3'd0, 16'sh7fff);
    send_cmd(KIND_RUN, 3'd7, 3'd7, -16'sh8000);
    // negative saturation, clipped to zero by ReLU
    send_cmd(KIND_A, 3'd0, 3'd0, -16'sh8000);
    send_cmd(KIND_C, 3'd0, 3'd0, -16'sh8000);
    send_cmd(KIND_RUN, 3'd0, 3'd0, 16'sh7fff);
    // half-LSB products: a tie rounds toward plus infinity
    send_cmd(KIND_A, 3'd0, 3'd0, 16'sd128);
    send_cmd(KIND_B, 3'd0, 3'd0, 16'sd1);
    send_cmd(KIND_C, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_RUN, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_B, 3'd0, 3'd0, -16'sd1);
    send_cmd(KIND_C, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_RUN, 3'd0, 3'd0, 16'sd0);
    // sigmoid: with A at one the sum equals B, so steer the table index
    configure(4'd1, 4'd1, 4'd1, 4'd1);
    send_cmd(KIND_A, 3'd0, 3'd0, 16'sd256);
    send_cmd(KIND_B, 3'd0, 3'd0, -16'sd2049);
    send_cmd(KIND_C, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_RUN, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_B, 3'd0, 3'd0, 16'sd2047);
    send_cmd(KIND_C, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_RUN, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_B, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_C, 3'd0, 3'd0, 16'sd0);
    send_cmd(KIND_RUN, 3'd0, 3'd0, 16'sd0);

    // Random phases: new settings, loads mostly inside the used region,
    // some noise anywhere in the stores, and computes.
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (phase == 2) begin
        configure(4'd8, 4'd8, 4'd2, 4'($urandom_range(0, 15)));
        cmd_steady = 1'b1;
        res_steady = 1'b0;
        // stall results mid-compute while loads keep coming behind it
        long_hold_req = 1'b1;
        run_product();
      end else begin
        configure(pick_dim(), pick_dim(), pick_dim(), 4'($urandom_range(0, 15)));
        cmd_steady = ($urandom_range(0, 3) == 0);
        res_steady = ($urandom_range(0, 3) == 0);
      end
      ops = $urandom_range(4, 14);
      repeat (ops) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            run_product();
            // sometimes let the whole result matrix drain before going on
            if ($urandom_range(0, 7) == 0) pause_until_drained();
          end
          2, 3, 4: send_cmd(KIND_A, 3'($urandom_range(0, rows_eff - 1)),
                            3'($urandom_range(0, inner_eff - 1)), pick_value());
          5, 6: send_cmd(KIND_B, 3'($urandom_range(0, inner_eff - 1)),
                         3'($urandom_range(0, cols_eff - 1)), pick_value());
          7, 8: send_cmd(KIND_C, 3'($urandom_range(0, rows_eff - 1)),
                         3'($urandom_range(0, cols_eff - 1)), pick_value());
          default: send_cmd(kind_t'($urandom_range(0, 2)), 3'($urandom),
                            3'($urandom), 16'($urandom));
        endcase
      end
      run_product();
      phase++;
    end

    // Drain, give the block time to show stray results, then judge.
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mac_pkg.sv
rtl/mac_in_if.sv
rtl/mac_out_if.sv
rtl/mac_cfg_if.sv
rtl/mac_ram.sv
rtl/matmul_accumulate_activation.sv
bench/mac_result_checker.sv
bench/tb_matmul_accumulate_activation.sv
